>>> hw/rtl/kvr_pkg.sv
// ----------------------------------------------------------------------------
// kvr_pkg: shared types and constants for the KV ring slot and mask tracker
// Field widths, configuration register indexes, queue descriptor, result
// record and back-end state encoding.
// ----------------------------------------------------------------------------
package kvr_pkg;

  // Default sizing, handed to the top-level parameters
  localparam int DEF_RING_SLOTS = 1024;
  localparam int DEF_MAX_BLOCK  = 16;

  // Field widths
  localparam int POS_W      = 31;  // absolute positions, committed lengths
  localparam int COL_W      = 11;  // mask column
  localparam int ROW_W      = 4;   // query row
  localparam int CNT_W      = 11;  // append_count
  localparam int PAD_W      = 6;   // pad_count
  localparam int SLOT_W     = POS_W + 1;  // stored slot word: {valid, position}
  localparam int CAPCFG_W   = 11;
  localparam int BLKCFG_W   = 5;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 31;

  // Remainder unit runs one dividend bit per cycle
  localparam int MOD_STEPS = POS_W;
  localparam int MOD_CNT_W = $clog2(MOD_STEPS);

  // Queue between front and back
  localparam int QUEUE_DEPTH = 2;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_RING_CAPACITY    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_LEN        = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SWA_WINDOW       = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_FULL_MASK_ENABLE = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_SWA_MASK_ENABLE  = 3'd4;

  // Configuration reset values
  localparam logic [CAPCFG_W-1:0] RST_RING_CAPACITY = 11'd1024;
  localparam logic [BLKCFG_W-1:0] RST_BLOCK_LEN     = 5'd16;
  localparam logic [POS_W-1:0]    RST_SWA_WINDOW    = '0;
  localparam logic                RST_FULL_EN       = 1'b1;
  localparam logic                RST_SWA_EN        = 1'b0;

  // Input kind codes
  localparam logic KIND_ADVANCE = 1'b0;
  localparam logic KIND_QUERY   = 1'b1;

  typedef enum logic [1:0] {
    OP_ADVANCE,      // advance to a nonzero committed length
    OP_REJECT,       // advance with committed length zero
    OP_QUERY_SLOT,   // mask query on a ring slot column
    OP_QUERY_FIXED   // mask query whose answer needs no slot read
  } op_t;

  typedef struct packed {
    op_t              op;
    logic [POS_W-1:0] committed;
    logic [COL_W-1:0] column;
    logic             vis_full;  // slot query: mask gate; fixed query: answer
    logic             vis_swa;
  } desc_t;

  typedef struct packed {
    logic [POS_W-1:0] swa_len;
    logic             full_en;
    logic             swa_en;
  } mask_cfg_t;

  typedef struct packed {
    logic             status;
    logic             rewound;
    logic             bulk;
    logic [POS_W-1:0] append_start;
    logic [CNT_W-1:0] append_count;
    logic [PAD_W-1:0] pad_count;
    logic             visible_full;
    logic             visible_swa;
  } res_t;

  typedef enum logic [3:0] {
    ST_INIT_CLR,
    ST_IDLE,
    ST_ADV_A,
    ST_REW_CLR,
    ST_ADV_B,
    ST_ADV_C,
    ST_MOD,
    ST_WRITE,
    ST_EMIT,
    ST_QRD
  } bst_t;

endpackage

>>> hw/rtl/kvr_fifo.sv
// ----------------------------------------------------------------------------
// kvr_fifo: descriptor queue between front and back
// Small register queue; push and pop may happen in the same cycle.
// ----------------------------------------------------------------------------
module kvr_fifo (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  kvr_pkg::desc_t  push_data,
  output logic            full,
  input  logic            pop,
  output kvr_pkg::desc_t  pop_data,
  output logic            empty
);

  localparam int DEPTH = kvr_pkg::QUEUE_DEPTH;
  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  kvr_pkg::desc_t    entry_r [DEPTH];
  logic [PTR_W-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0]  count_r, count_nxt;
  logic              do_push, do_pop;

  assign full     = (count_r == CNT_W'(DEPTH));
  assign empty    = (count_r == '0);
  assign pop_data = entry_r[rd_ptr_r];
  assign do_push  = push && !full;
  assign do_pop   = pop && !empty;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : PTR_W'(wr_ptr_r + 1'b1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : PTR_W'(rd_ptr_r + 1'b1);
    end
    if (do_push && !do_pop) begin
      count_nxt = CNT_W'(count_r + 1'b1);
    end else if (do_pop && !do_push) begin
      count_nxt = CNT_W'(count_r - 1'b1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      entry_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

>>> hw/rtl/kvr_front.sv
// ----------------------------------------------------------------------------
// kvr_front: input acceptance and classification
// Sorts each transaction into advance, rejected advance, slot query or
// fixed-answer query and pushes a descriptor into the queue.
// ----------------------------------------------------------------------------
module kvr_front #(
  parameter int RING_SLOTS = kvr_pkg::DEF_RING_SLOTS,
  parameter int MAX_BLOCK  = kvr_pkg::DEF_MAX_BLOCK
) (
  input  logic [$clog2(RING_SLOTS+1)-1:0] cap,
  input  logic [$clog2(MAX_BLOCK+1)-1:0]  blk,
  input  kvr_pkg::mask_cfg_t          mcfg,
  input  logic                        init_busy,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic                        in_kind,
  input  logic [kvr_pkg::POS_W-1:0]   in_committed,
  input  logic [kvr_pkg::COL_W-1:0]   in_column,
  input  logic [kvr_pkg::ROW_W-1:0]   in_query_row,
  input  logic                        q_full,
  output logic                        q_push,
  output kvr_pkg::desc_t              q_desc
);

  localparam int CAP_W = $clog2(RING_SLOTS + 1);
  localparam int BLK_W = $clog2(MAX_BLOCK + 1);
  localparam int CW    = ((kvr_pkg::COL_W > CAP_W) ? kvr_pkg::COL_W : CAP_W) + 1;
  localparam int RW    = (kvr_pkg::ROW_W > BLK_W) ? kvr_pkg::ROW_W : BLK_W;

  logic          row_ok, in_slot, in_noise, noise_le;
  logic [CW-1:0] col_e, cap_e, noise_idx;

  // Hold off new transactions while the slot store is swept after reset
  assign in_ready = !q_full && !init_busy;
  assign q_push   = in_valid && in_ready;

  assign row_ok    = RW'(in_query_row) < RW'(blk);
  assign col_e     = CW'(in_column);
  assign cap_e     = CW'(cap);
  assign in_slot   = col_e < cap_e;
  assign in_noise  = !in_slot && (col_e < CW'(cap_e + CW'(blk)));
  assign noise_idx = CW'(col_e - cap_e);
  assign noise_le  = noise_idx <= CW'(in_query_row);

  always_comb begin
    q_desc.committed = in_committed;
    q_desc.column    = in_column;
    q_desc.vis_full  = 1'b0;
    q_desc.vis_swa   = 1'b0;
    if (in_kind == kvr_pkg::KIND_ADVANCE) begin
      q_desc.op = (in_committed == '0) ? kvr_pkg::OP_REJECT : kvr_pkg::OP_ADVANCE;
    end else if (in_slot) begin
      q_desc.op       = kvr_pkg::OP_QUERY_SLOT;
      q_desc.vis_full = mcfg.full_en && row_ok;
      q_desc.vis_swa  = mcfg.swa_en && row_ok;
    end else begin
      q_desc.op       = kvr_pkg::OP_QUERY_FIXED;
      q_desc.vis_full = mcfg.full_en && row_ok && in_noise;
      q_desc.vis_swa  = mcfg.swa_en && row_ok && in_noise && noise_le;
    end
  end

endmodule

>>> hw/rtl/kvr_mod.sv
// ----------------------------------------------------------------------------
// kvr_mod: restoring remainder unit
// Computes dividend mod divisor, one dividend bit per cycle.
// ----------------------------------------------------------------------------
module kvr_mod #(
  parameter int RING_SLOTS = kvr_pkg::DEF_RING_SLOTS
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              go,
  input  logic [kvr_pkg::POS_W-1:0]         dividend,
  input  logic [$clog2(RING_SLOTS+1)-1:0]   divisor,
  output logic                              done,
  output logic [$clog2(RING_SLOTS+1)-1:0]   rem
);

  localparam int CAP_W = $clog2(RING_SLOTS + 1);
  localparam int MCW   = kvr_pkg::MOD_CNT_W;

  logic                      busy_r, busy_nxt;
  logic                      done_r, done_nxt;
  logic [MCW-1:0]            cnt_r, cnt_nxt;
  logic [kvr_pkg::POS_W-1:0] div_r, div_nxt;
  logic [CAP_W-1:0]          rem_r, rem_nxt;
  logic [CAP_W:0]            trial;

  assign done  = done_r;
  assign rem   = rem_r;
  assign trial = {rem_r, div_r[kvr_pkg::POS_W-1]};

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    div_nxt  = div_r;
    rem_nxt  = rem_r;
    if (go) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      div_nxt  = dividend;
      rem_nxt  = '0;
    end else if (busy_r) begin
      // Shift in one dividend bit, subtract the divisor when it fits
      if (trial >= {1'b0, divisor}) begin
        rem_nxt = CAP_W'(trial - {1'b0, divisor});
      end else begin
        rem_nxt = CAP_W'(trial);
      end
      div_nxt = {div_r[kvr_pkg::POS_W-2:0], 1'b0};
      cnt_nxt = MCW'(cnt_r + 1'b1);
      if (cnt_r == MCW'(kvr_pkg::MOD_STEPS - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    div_r <= div_nxt;
    rem_r <= rem_nxt;
  end

endmodule

>>> hw/rtl/kvr_back.sv
// ----------------------------------------------------------------------------
// kvr_back: slot store, advance sequencer and mask lookup
// Owns the slot memory and the window state, carries out queued
// descriptors and holds the result register.
// ----------------------------------------------------------------------------
module kvr_back #(
  parameter int RING_SLOTS = kvr_pkg::DEF_RING_SLOTS,
  parameter int MAX_BLOCK  = kvr_pkg::DEF_MAX_BLOCK
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic [$clog2(RING_SLOTS+1)-1:0]   cap,
  input  logic [$clog2(MAX_BLOCK+1)-1:0]    blk,
  input  kvr_pkg::mask_cfg_t                mcfg,
  input  logic                              q_empty,
  input  kvr_pkg::desc_t                    q_data,
  output logic                              q_pop,
  output logic                              mod_go,
  output logic [kvr_pkg::POS_W-1:0]         mod_dividend,
  input  logic                              mod_done,
  input  logic [$clog2(RING_SLOTS+1)-1:0]   mod_rem,
  output logic                              init_busy,
  output logic                              out_valid,
  input  logic                              out_ready,
  output kvr_pkg::res_t                     out_res
);

  localparam int POS_W = kvr_pkg::POS_W;
  localparam int CAP_W = $clog2(RING_SLOTS + 1);
  localparam int BLK_W = $clog2(MAX_BLOCK + 1);
  localparam int IDX_W = (RING_SLOTS > 1) ? $clog2(RING_SLOTS) : 1;
  localparam int AS_W  = BLK_W + 2;
  localparam int CMP_W = (CAP_W > AS_W) ? CAP_W : AS_W;

  // Slot store: {valid, position}
  logic [kvr_pkg::SLOT_W-1:0] slot_mem [RING_SLOTS];
  logic [kvr_pkg::SLOT_W-1:0] rd_data_r;
  logic                       mem_we, mem_re;
  logic [IDX_W-1:0]           mem_waddr, mem_raddr;
  logic [kvr_pkg::SLOT_W-1:0] mem_wdata;

  kvr_pkg::bst_t    state_r, state_nxt;
  logic [IDX_W-1:0] clr_idx_r, clr_idx_nxt;
  logic [POS_W-1:0] head_pos_r, head_pos_nxt;
  logic [POS_W-1:0] last_comm_r, last_comm_nxt;
  logic [POS_W-1:0] win_low_r, win_low_nxt;
  logic [POS_W-1:0] swa_low_r, swa_low_nxt;
  logic             out_valid_r, out_valid_nxt;

  logic [POS_W-1:0] cur_comm_r, cur_comm_nxt;
  logic             rewind_r, rewind_nxt;
  logic [CAP_W-1:0] win_r, win_nxt;
  logic [POS_W-1:0] base_r, base_nxt;
  logic [POS_W-1:0] lo_r, lo_nxt;
  logic [POS_W-1:0] swa_new_r, swa_new_nxt;
  logic [POS_W-1:0] start_r, start_nxt;
  logic [CAP_W-1:0] nnew_r, nnew_nxt;
  logic [POS_W-1:0] wr_pos_r, wr_pos_nxt;
  logic [IDX_W-1:0] wr_slot_r, wr_slot_nxt;
  logic             qv_full_r, qv_full_nxt;
  logic             qv_swa_r, qv_swa_nxt;
  kvr_pkg::res_t    out_res_r;

  logic             out_free, out_load, clr_last, wr_last, can_pop;
  kvr_pkg::res_t    res_c;
  logic [POS_W-1:0] win_ext, eff_win, start_c, slot_tag;
  logic [AS_W-1:0]  a_step;
  logic             bulk_c, slot_valid;

  assign out_free  = !out_valid_r || out_ready;
  assign out_valid = out_valid_r;
  assign out_res   = out_res_r;
  assign init_busy = (state_r == kvr_pkg::ST_INIT_CLR);
  assign clr_last  = (clr_idx_r == IDX_W'(RING_SLOTS - 1));
  assign wr_last   = (POS_W'(wr_pos_r + 1'b1) == cur_comm_r);
  assign can_pop   = !q_empty
                  && ((q_data.op == kvr_pkg::OP_ADVANCE) || out_free);
  assign q_pop     = (state_r == kvr_pkg::ST_IDLE) && can_pop;

  assign win_ext    = POS_W'(win_r);
  assign eff_win    = ((mcfg.swa_len != '0) && (win_ext > mcfg.swa_len))
                    ? mcfg.swa_len : win_ext;
  assign start_c    = (base_r > lo_r) ? base_r : lo_r;
  assign a_step     = AS_W'({blk, 1'b0} + AS_W'(2));
  assign bulk_c     = CMP_W'(nnew_r) > CMP_W'(a_step);
  assign slot_valid = rd_data_r[kvr_pkg::SLOT_W-1];
  assign slot_tag   = rd_data_r[POS_W-1:0];

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      kvr_pkg::ST_INIT_CLR: begin
        if (clr_last) state_nxt = kvr_pkg::ST_IDLE;
      end
      kvr_pkg::ST_IDLE: begin
        if (can_pop) begin
          case (q_data.op)
            kvr_pkg::OP_ADVANCE:    state_nxt = kvr_pkg::ST_ADV_A;
            kvr_pkg::OP_QUERY_SLOT: state_nxt = kvr_pkg::ST_QRD;
            default:                state_nxt = kvr_pkg::ST_IDLE;
          endcase
        end
      end
      kvr_pkg::ST_ADV_A: begin
        state_nxt = (head_pos_r > cur_comm_r) ? kvr_pkg::ST_REW_CLR : kvr_pkg::ST_ADV_B;
      end
      kvr_pkg::ST_REW_CLR: begin
        if (clr_last) state_nxt = kvr_pkg::ST_ADV_B;
      end
      kvr_pkg::ST_ADV_B: state_nxt = kvr_pkg::ST_ADV_C;
      kvr_pkg::ST_ADV_C: state_nxt = kvr_pkg::ST_MOD;
      kvr_pkg::ST_MOD: begin
        if (mod_done) state_nxt = (nnew_r == '0) ? kvr_pkg::ST_EMIT : kvr_pkg::ST_WRITE;
      end
      kvr_pkg::ST_WRITE: begin
        if (wr_last) state_nxt = kvr_pkg::ST_EMIT;
      end
      kvr_pkg::ST_EMIT: begin
        if (out_free) state_nxt = kvr_pkg::ST_IDLE;
      end
      kvr_pkg::ST_QRD: state_nxt = kvr_pkg::ST_IDLE;
      default: state_nxt = kvr_pkg::ST_IDLE;
    endcase
  end

  // Datapath and outputs
  always_comb begin
    clr_idx_nxt   = clr_idx_r;
    head_pos_nxt  = head_pos_r;
    last_comm_nxt = last_comm_r;
    win_low_nxt   = win_low_r;
    swa_low_nxt   = swa_low_r;
    cur_comm_nxt  = cur_comm_r;
    rewind_nxt    = rewind_r;
    win_nxt       = win_r;
    base_nxt      = base_r;
    lo_nxt        = lo_r;
    swa_new_nxt   = swa_new_r;
    start_nxt     = start_r;
    nnew_nxt      = nnew_r;
    wr_pos_nxt    = wr_pos_r;
    wr_slot_nxt   = wr_slot_r;
    qv_full_nxt   = qv_full_r;
    qv_swa_nxt    = qv_swa_r;
    mem_we        = 1'b0;
    mem_waddr     = clr_idx_r;
    mem_wdata     = '0;
    mem_re        = 1'b0;
    mem_raddr     = IDX_W'(q_data.column);
    mod_go        = 1'b0;
    mod_dividend  = start_c;
    out_load      = 1'b0;
    res_c         = '0;

    case (state_r)
      kvr_pkg::ST_INIT_CLR, kvr_pkg::ST_REW_CLR: begin
        // Sweep every entry to empty
        mem_we      = 1'b1;
        clr_idx_nxt = clr_last ? '0 : IDX_W'(clr_idx_r + 1'b1);
      end
      kvr_pkg::ST_IDLE: begin
        if (can_pop) begin
          cur_comm_nxt = q_data.committed;
          qv_full_nxt  = q_data.vis_full;
          qv_swa_nxt   = q_data.vis_swa;
          mem_re       = (q_data.op == kvr_pkg::OP_QUERY_SLOT);
          case (q_data.op)
            kvr_pkg::OP_REJECT: begin
              out_load     = 1'b1;
              res_c.status = 1'b1;
            end
            kvr_pkg::OP_QUERY_FIXED: begin
              out_load           = 1'b1;
              res_c.visible_full = q_data.vis_full;
              res_c.visible_swa  = q_data.vis_swa;
            end
            default: ;
          endcase
        end
      end
      kvr_pkg::ST_ADV_A: begin
        rewind_nxt  = head_pos_r > cur_comm_r;
        base_nxt    = (head_pos_r > cur_comm_r) ? '0 : head_pos_r;
        win_nxt     = (cur_comm_r < POS_W'(cap)) ? CAP_W'(cur_comm_r) : cap;
        clr_idx_nxt = '0;
      end
      kvr_pkg::ST_ADV_B: begin
        lo_nxt      = POS_W'(cur_comm_r - win_ext);
        swa_new_nxt = POS_W'(cur_comm_r - eff_win);
      end
      kvr_pkg::ST_ADV_C: begin
        start_nxt = start_c;
        nnew_nxt  = CAP_W'(cur_comm_r - start_c);
        mod_go    = 1'b1;
      end
      kvr_pkg::ST_MOD: begin
        if (mod_done) begin
          wr_slot_nxt = IDX_W'(mod_rem);
          wr_pos_nxt  = start_r;
        end
      end
      kvr_pkg::ST_WRITE: begin
        mem_we      = 1'b1;
        mem_waddr   = wr_slot_r;
        mem_wdata   = {1'b1, wr_pos_r};
        wr_pos_nxt  = POS_W'(wr_pos_r + 1'b1);
        wr_slot_nxt = (CAP_W'(wr_slot_r) == CAP_W'(cap - 1'b1))
                    ? '0 : IDX_W'(wr_slot_r + 1'b1);
      end
      kvr_pkg::ST_EMIT: begin
        if (out_free) begin
          out_load           = 1'b1;
          res_c.rewound      = rewind_r;
          res_c.bulk         = bulk_c;
          res_c.append_start = start_r;
          res_c.append_count = kvr_pkg::CNT_W'(nnew_r);
          res_c.pad_count    = bulk_c ? '0
                             : kvr_pkg::PAD_W'(CMP_W'(a_step) - CMP_W'(nnew_r));
          head_pos_nxt       = cur_comm_r;
          last_comm_nxt      = cur_comm_r;
          win_low_nxt        = lo_r;
          swa_low_nxt        = swa_new_r;
        end
      end
      kvr_pkg::ST_QRD: begin
        out_load           = 1'b1;
        res_c.visible_full = qv_full_r && slot_valid
                          && (slot_tag >= win_low_r) && (slot_tag < last_comm_r);
        res_c.visible_swa  = qv_swa_r && slot_valid
                          && (slot_tag >= swa_low_r) && (slot_tag < last_comm_r);
      end
      default: ;
    endcase

    out_valid_nxt = out_load ? 1'b1 : (out_ready ? 1'b0 : out_valid_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= kvr_pkg::ST_INIT_CLR;
      clr_idx_r   <= '0;
      head_pos_r  <= '0;
      last_comm_r <= '0;
      win_low_r   <= '0;
      swa_low_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_idx_r   <= clr_idx_nxt;
      head_pos_r  <= head_pos_nxt;
      last_comm_r <= last_comm_nxt;
      win_low_r   <= win_low_nxt;
      swa_low_r   <= swa_low_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cur_comm_r <= cur_comm_nxt;
    rewind_r   <= rewind_nxt;
    win_r      <= win_nxt;
    base_r     <= base_nxt;
    lo_r       <= lo_nxt;
    swa_new_r  <= swa_new_nxt;
    start_r    <= start_nxt;
    nnew_r     <= nnew_nxt;
    wr_pos_r   <= wr_pos_nxt;
    wr_slot_r  <= wr_slot_nxt;
    qv_full_r  <= qv_full_nxt;
    qv_swa_r   <= qv_swa_nxt;
    if (out_load) begin
      out_res_r <= res_c;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      slot_mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rd_data_r <= slot_mem[mem_raddr];
    end
  end

endmodule

>>> hw/rtl/kv_ring_slot_and_mask_tracker_core.sv
// ----------------------------------------------------------------------------
// kv_ring_slot_and_mask_tracker_core: KV cache ring slot and mask tracker
// Tracks which absolute position each context slot holds, advances the
// ring on committed lengths and answers attention mask visibility queries.
// ----------------------------------------------------------------------------
//
//  Port group  Direction  Handshake            Moves
//  in_*        input      in_valid/in_ready    advance or mask query transaction
//  out_*       output     out_valid/out_ready  one result transaction per input
//  cfg_*       input      cfg_we only          register write, index and data
//
//  Steps: the back end answers a rejected advance or a fixed-answer query at the
//  pop and a slot-column query after a slot read; an advance runs a pop, setup
//  states ADV_A to ADV_C, the bit-serial remainder unit, one slot write per new
//  position and an emit. A rewind adds a sweep of the slot memory to empty.
//  Reset: the slot memory is swept to empty with in_ready low.
//  Stalls: a two-entry queue parts front and back; a full result register holds.
//
module kv_ring_slot_and_mask_tracker_core #(
  parameter int RING_SLOTS = kvr_pkg::DEF_RING_SLOTS,
  parameter int MAX_BLOCK  = kvr_pkg::DEF_MAX_BLOCK
) (
  input  logic                             clk,
  input  logic                             rst_n,

  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic                             in_kind,
  input  logic [kvr_pkg::POS_W-1:0]        in_committed,
  input  logic [kvr_pkg::COL_W-1:0]        in_column,
  input  logic [kvr_pkg::ROW_W-1:0]        in_query_row,

  output logic                             out_valid,
  input  logic                             out_ready,
  output logic                             out_status,
  output logic                             out_rewound,
  output logic                             out_bulk,
  output logic [kvr_pkg::POS_W-1:0]        out_append_start,
  output logic [kvr_pkg::CNT_W-1:0]        out_append_count,
  output logic [kvr_pkg::PAD_W-1:0]        out_pad_count,
  output logic                             out_visible_full,
  output logic                             out_visible_swa,

  input  logic                             cfg_we,
  input  logic [kvr_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [kvr_pkg::CFG_DATA_W-1:0]   cfg_wdata
);

  localparam int CAP_W = $clog2(RING_SLOTS + 1);
  localparam int BLK_W = $clog2(MAX_BLOCK + 1);

  // Configuration registers
  logic [kvr_pkg::CAPCFG_W-1:0] cap_cfg_r, cap_cfg_nxt;
  logic [kvr_pkg::BLKCFG_W-1:0] blk_cfg_r, blk_cfg_nxt;
  logic [kvr_pkg::POS_W-1:0]    swa_win_r, swa_win_nxt;
  logic                         full_en_r, full_en_nxt;
  logic                         swa_en_r, swa_en_nxt;

  logic [CAP_W-1:0]    cap_eff;
  logic [BLK_W-1:0]    blk_eff;
  kvr_pkg::mask_cfg_t  mcfg;

  logic                q_full, q_empty, q_push, q_pop;
  kvr_pkg::desc_t      q_desc, q_data;
  logic                init_busy;
  logic                mod_go, mod_done;
  logic [kvr_pkg::POS_W-1:0] mod_dividend;
  logic [CAP_W-1:0]    mod_rem;
  kvr_pkg::res_t       res;

  // Decode the register write; unknown indexes are dropped
  always_comb begin
    cap_cfg_nxt = cap_cfg_r;
    blk_cfg_nxt = blk_cfg_r;
    swa_win_nxt = swa_win_r;
    full_en_nxt = full_en_r;
    swa_en_nxt  = swa_en_r;
    if (cfg_we) begin
      case (cfg_index)
        kvr_pkg::CFG_RING_CAPACITY:    cap_cfg_nxt = cfg_wdata[kvr_pkg::CAPCFG_W-1:0];
        kvr_pkg::CFG_BLOCK_LEN:        blk_cfg_nxt = cfg_wdata[kvr_pkg::BLKCFG_W-1:0];
        kvr_pkg::CFG_SWA_WINDOW:       swa_win_nxt = cfg_wdata[kvr_pkg::POS_W-1:0];
        kvr_pkg::CFG_FULL_MASK_ENABLE: full_en_nxt = cfg_wdata[0];
        kvr_pkg::CFG_SWA_MASK_ENABLE:  swa_en_nxt  = cfg_wdata[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_cfg_r <= kvr_pkg::RST_RING_CAPACITY;
      blk_cfg_r <= kvr_pkg::RST_BLOCK_LEN;
      swa_win_r <= kvr_pkg::RST_SWA_WINDOW;
      full_en_r <= kvr_pkg::RST_FULL_EN;
      swa_en_r  <= kvr_pkg::RST_SWA_EN;
    end else begin
      cap_cfg_r <= cap_cfg_nxt;
      blk_cfg_r <= blk_cfg_nxt;
      swa_win_r <= swa_win_nxt;
      full_en_r <= full_en_nxt;
      swa_en_r  <= swa_en_nxt;
    end
  end

  // Clamp capacity to 1..RING_SLOTS and block length to 1..MAX_BLOCK
  always_comb begin
    if (cap_cfg_r == '0) begin
      cap_eff = CAP_W'(1);
    end else if (32'(cap_cfg_r) > 32'(RING_SLOTS)) begin
      cap_eff = CAP_W'(RING_SLOTS);
    end else begin
      cap_eff = CAP_W'(cap_cfg_r);
    end
    if (blk_cfg_r == '0) begin
      blk_eff = BLK_W'(1);
    end else if (32'(blk_cfg_r) > 32'(MAX_BLOCK)) begin
      blk_eff = BLK_W'(MAX_BLOCK);
    end else begin
      blk_eff = BLK_W'(blk_cfg_r);
    end
  end

  assign mcfg.swa_len = swa_win_r;
  assign mcfg.full_en = full_en_r;
  assign mcfg.swa_en  = swa_en_r;

  // Front: accept and classify
  kvr_front #(
    .RING_SLOTS (RING_SLOTS),
    .MAX_BLOCK  (MAX_BLOCK)
  ) u_front (
    .cap          (cap_eff),
    .blk          (blk_eff),
    .mcfg         (mcfg),
    .init_busy    (init_busy),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_kind      (in_kind),
    .in_committed (in_committed),
    .in_column    (in_column),
    .in_query_row (in_query_row),
    .q_full       (q_full),
    .q_push       (q_push),
    .q_desc       (q_desc)
  );

  // Queue: decouple front from back
  kvr_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_desc),
    .full      (q_full),
    .pop       (q_pop),
    .pop_data  (q_data),
    .empty     (q_empty)
  );

  // Remainder unit: first slot of an append run
  kvr_mod #(
    .RING_SLOTS (RING_SLOTS)
  ) u_mod (
    .clk      (clk),
    .rst_n    (rst_n),
    .go       (mod_go),
    .dividend (mod_dividend),
    .divisor  (cap_eff),
    .done     (mod_done),
    .rem      (mod_rem)
  );

  // Back: slot store, advance sequencing, mask lookup, result register
  kvr_back #(
    .RING_SLOTS (RING_SLOTS),
    .MAX_BLOCK  (MAX_BLOCK)
  ) u_back (
    .clk          (clk),
    .rst_n        (rst_n),
    .cap          (cap_eff),
    .blk          (blk_eff),
    .mcfg         (mcfg),
    .q_empty      (q_empty),
    .q_data       (q_data),
    .q_pop        (q_pop),
    .mod_go       (mod_go),
    .mod_dividend (mod_dividend),
    .mod_done     (mod_done),
    .mod_rem      (mod_rem),
    .init_busy    (init_busy),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_res      (res)
  );

  assign out_status       = res.status;
  assign out_rewound      = res.rewound;
  assign out_bulk         = res.bulk;
  assign out_append_start = res.append_start;
  assign out_append_count = res.append_count;
  assign out_pad_count    = res.pad_count;
  assign out_visible_full = res.visible_full;
  assign out_visible_swa  = res.visible_swa;

endmodule

>>> bench/testbench.sv
// ----------------------------------------------------------------------------
// testbench: self-checking bench for the KV ring slot and mask tracker
// Drives advance and mask-query transactions with random idle gaps on both
// channels, predicts every result from a private copy of the ring state and
// compares each returned result field by field against the oldest prediction.
// ----------------------------------------------------------------------------
module testbench;

  // Cycles without any accepted transaction before the run is called hung.
  localparam int STALL_LIMIT = 20000;
  localparam longint POS_MAX = 64'h7FFF_FFFF;

  typedef struct packed {
    logic                      kind;
    logic [kvr_pkg::POS_W-1:0] committed;
    logic [kvr_pkg::COL_W-1:0] column;
    logic [kvr_pkg::ROW_W-1:0] row;
  } ring_req_t;

  // --------------------------------------------------------------------------
  // Ring state mirror and queue of predicted results
  // --------------------------------------------------------------------------
  class ring_mask_scoreboard;
    logic [kvr_pkg::CAPCFG_W-1:0] capacity_reg;
    logic [kvr_pkg::BLKCFG_W-1:0] block_reg;
    logic [kvr_pkg::POS_W-1:0]    swa_reg;
    logic                         full_on;
    logic                         swa_on;
    int                           ring_tag [kvr_pkg::DEF_RING_SLOTS];
    longint                       head_pos;
    longint                       last_len;
    longint                       full_low;
    longint                       swa_low;
    kvr_pkg::res_t                expected_results [$];
    int                           mismatches;

    function void power_on();
      capacity_reg = kvr_pkg::RST_RING_CAPACITY;
      block_reg    = kvr_pkg::RST_BLOCK_LEN;
      swa_reg      = kvr_pkg::RST_SWA_WINDOW;
      full_on      = kvr_pkg::RST_FULL_EN;
      swa_on       = kvr_pkg::RST_SWA_EN;
      foreach (ring_tag[i]) ring_tag[i] = -1;
      head_pos   = 0;
      last_len   = 0;
      full_low   = 0;
      swa_low    = 0;
      mismatches = 0;
    endfunction

    function longint eff_capacity();
      if (capacity_reg == 0) return 1;
      if (capacity_reg > kvr_pkg::DEF_RING_SLOTS) return kvr_pkg::DEF_RING_SLOTS;
      return longint'(capacity_reg);
    endfunction

    function longint eff_block();
      if (block_reg == 0) return 1;
      if (block_reg > kvr_pkg::DEF_MAX_BLOCK) return kvr_pkg::DEF_MAX_BLOCK;
      return longint'(block_reg);
    endfunction

    function void set_reg(logic [kvr_pkg::CFG_IDX_W-1:0] idx,
                          logic [kvr_pkg::CFG_DATA_W-1:0] data);
      case (idx)
        kvr_pkg::CFG_RING_CAPACITY:    capacity_reg = data[kvr_pkg::CAPCFG_W-1:0];
        kvr_pkg::CFG_BLOCK_LEN:        block_reg    = data[kvr_pkg::BLKCFG_W-1:0];
        kvr_pkg::CFG_SWA_WINDOW:       swa_reg      = data[kvr_pkg::POS_W-1:0];
        kvr_pkg::CFG_FULL_MASK_ENABLE: full_on      = data[0];
        kvr_pkg::CFG_SWA_MASK_ENABLE:  swa_on       = data[0];
        default: ;
      endcase
    endfunction

    function kvr_pkg::res_t ring_outcome(ring_req_t rq);
      kvr_pkg::res_t r;
      longint cap, blk, step, len, win, lo, start, n_new, swin, p, col, noise;
      r   = '0;
      cap = eff_capacity();
      blk = eff_block();
      if (rq.kind == kvr_pkg::KIND_ADVANCE) begin
        step = 2 * blk + 2;
        len  = longint'(rq.committed);
        // a zero length is refused and leaves the ring alone
        if (len == 0) begin
          r.status = 1'b1;
          return r;
        end
        // moving backwards empties every slot and restarts from zero
        if (head_pos > len) begin
          foreach (ring_tag[i]) ring_tag[i] = -1;
          head_pos  = 0;
          r.rewound = 1'b1;
        end
        win   = (len < cap) ? len : cap;
        lo    = len - win;
        start = (head_pos > lo) ? head_pos : lo;
        n_new = len - start;
        for (p = start; p < len; p++) ring_tag[p % cap] = int'(p);
        if (n_new > step) r.bulk = 1'b1;
        else r.pad_count = kvr_pkg::PAD_W'(step - n_new);
        r.append_start = start[kvr_pkg::POS_W-1:0];
        r.append_count = kvr_pkg::CNT_W'(n_new);
        swin = (swa_reg != 0 && win > longint'(swa_reg)) ? longint'(swa_reg) : win;
        head_pos = len;
        last_len = len;
        full_low = lo;
        swa_low  = len - swin;
        return r;
      end
      if (longint'(rq.row) >= blk) return r;
      col = longint'(rq.column);
      if (col < cap) begin
        p = longint'(ring_tag[col]);
        if (full_on && p >= full_low && p < last_len) r.visible_full = 1'b1;
        if (swa_on && p >= swa_low && p < last_len) r.visible_swa = 1'b1;
      end else if (col < cap + blk) begin
        // noise columns: always in the full mask, causal in the sliding one
        noise = col - cap;
        if (full_on) r.visible_full = 1'b1;
        if (swa_on && noise <= longint'(rq.row)) r.visible_swa = 1'b1;
      end
      return r;
    endfunction

    function void note_request(ring_req_t rq);
      expected_results.push_back(ring_outcome(rq));
    endfunction

    function int field_diff(string name, longint exp_val, longint act_val);
      if (exp_val == act_val) return 0;
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, exp_val,
               act_val);
      return 1;
    endfunction

    function void check_result(kvr_pkg::res_t got);
      kvr_pkg::res_t e;
      if (expected_results.size() == 0) begin
        $display("%0t: result with no transaction pending, actual %h", $time, got);
        mismatches++;
        return;
      end
      e = expected_results.pop_front();
      mismatches += field_diff("status", e.status, got.status);
      mismatches += field_diff("rewound", e.rewound, got.rewound);
      mismatches += field_diff("bulk", e.bulk, got.bulk);
      mismatches += field_diff("append_start", e.append_start, got.append_start);
      mismatches += field_diff("append_count", e.append_count, got.append_count);
      mismatches += field_diff("pad_count", e.pad_count, got.pad_count);
      mismatches += field_diff("visible_full", e.visible_full, got.visible_full);
      mismatches += field_diff("visible_swa", e.visible_swa, got.visible_swa);
    endfunction
  endclass

  // --------------------------------------------------------------------------
  // Clock, reset and DUT
  // --------------------------------------------------------------------------
  logic clk;
  logic rst_n = 1'b0;

  logic                          in_valid     = 1'b0;
  logic                          in_ready;
  logic                          in_kind      = kvr_pkg::KIND_ADVANCE;
  logic [kvr_pkg::POS_W-1:0]     in_committed = '0;
  logic [kvr_pkg::COL_W-1:0]     in_column    = '0;
  logic [kvr_pkg::ROW_W-1:0]     in_query_row = '0;

  logic                          out_valid;
  logic                          out_ready    = 1'b0;
  logic                          out_status;
  logic                          out_rewound;
  logic                          out_bulk;
  logic [kvr_pkg::POS_W-1:0]     out_append_start;
  logic [kvr_pkg::CNT_W-1:0]     out_append_count;
  logic [kvr_pkg::PAD_W-1:0]     out_pad_count;
  logic                          out_visible_full;
  logic                          out_visible_swa;

  logic                          cfg_we    = 1'b0;
  logic [kvr_pkg::CFG_IDX_W-1:0] cfg_index = kvr_pkg::CFG_RING_CAPACITY;
  logic [kvr_pkg::CFG_DATA_W-1:0] cfg_wdata = '0;

  ring_mask_scoreboard sb;
  longint              frontier;   // last nonzero committed length sent
  bit                  calm = 1'b0; // both sides run without idling while set

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  kv_ring_slot_and_mask_tracker_core i_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_kind          (in_kind),
    .in_committed     (in_committed),
    .in_column        (in_column),
    .in_query_row     (in_query_row),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_status       (out_status),
    .out_rewound      (out_rewound),
    .out_bulk         (out_bulk),
    .out_append_start (out_append_start),
    .out_append_count (out_append_count),
    .out_pad_count    (out_pad_count),
    .out_visible_full (out_visible_full),
    .out_visible_swa  (out_visible_swa),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_wdata        (cfg_wdata)
  );

  // --------------------------------------------------------------------------
  // Drivers
  // --------------------------------------------------------------------------
  function automatic int draw_gap();
    return calm ? 0 : $urandom_range(0, 13);
  endfunction

  // Hold valid and payload until the transaction is taken. With a zero gap
  // valid simply stays high for the next transaction.
  task automatic send_request(ring_req_t rq);
    int gap;
    gap = draw_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_kind      <= rq.kind;
    in_committed <= rq.committed;
    in_column    <= rq.column;
    in_query_row <= rq.row;
    do @(posedge clk); while (!in_ready);
    sb.note_request(rq);
  endtask

  task automatic poke(logic kind, longint committed, int column, int row);
    ring_req_t rq;
    rq.kind      = kind;
    rq.committed = committed[kvr_pkg::POS_W-1:0];
    rq.column    = kvr_pkg::COL_W'(column);
    rq.row       = kvr_pkg::ROW_W'(row);
    if (kind == kvr_pkg::KIND_ADVANCE && committed != 0) frontier = committed;
    send_request(rq);
  endtask

  // Keep the enable high across back-to-back writes; drop it after the last.
  task automatic put_reg(logic [kvr_pkg::CFG_IDX_W-1:0] idx,
                         logic [kvr_pkg::CFG_DATA_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(posedge clk);
    sb.set_reg(idx, data);
  endtask

  task automatic program_regs(logic [kvr_pkg::CFG_DATA_W-1:0] cap,
                              logic [kvr_pkg::CFG_DATA_W-1:0] blk,
                              logic [kvr_pkg::CFG_DATA_W-1:0] swa,
                              logic full_en, logic swa_en);
    put_reg(kvr_pkg::CFG_RING_CAPACITY, cap);
    put_reg(kvr_pkg::CFG_BLOCK_LEN, blk);
    put_reg(kvr_pkg::CFG_SWA_WINDOW, swa);
    put_reg(kvr_pkg::CFG_FULL_MASK_ENABLE, kvr_pkg::CFG_DATA_W'(full_en));
    put_reg(kvr_pkg::CFG_SWA_MASK_ENABLE, kvr_pkg::CFG_DATA_W'(swa_en));
    cfg_we <= 1'b0;
  endtask

  // Stop sending and wait until every predicted result has been returned,
  // then let the back end settle.
  task automatic settle_idle();
    in_valid <= 1'b0;
    while (sb.expected_results.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  // Mostly well-formed traffic: forward advances from the current frontier and
  // queries aimed at slot and noise columns, with rewinds, refusals, far jumps
  // and out-of-range rows and columns mixed in.
  function automatic ring_req_t make_request();
    ring_req_t rq;
    longint    cap, blk, nxt;
    int        pick;
    cap          = sb.eff_capacity();
    blk          = sb.eff_block();
    rq.kind      = kvr_pkg::KIND_QUERY;
    rq.committed = kvr_pkg::POS_W'($urandom);
    pick         = $urandom_range(0, 99);
    if (pick < 55) begin
      pick = $urandom_range(0, 99);
      if (pick < 80) rq.column = kvr_pkg::COL_W'($urandom_range(0, int'(cap + blk + 2)));
      else if (pick < 95) rq.column = kvr_pkg::COL_W'($urandom_range(0, 1055));
      else rq.column = kvr_pkg::COL_W'($urandom);
      if ($urandom_range(0, 99) < 85) begin
        rq.row = kvr_pkg::ROW_W'($urandom_range(0, int'(blk - 1)));
      end else begin
        rq.row = kvr_pkg::ROW_W'($urandom);
      end
      return rq;
    end
    rq.kind   = kvr_pkg::KIND_ADVANCE;
    rq.column = kvr_pkg::COL_W'($urandom);
    rq.row    = kvr_pkg::ROW_W'($urandom);
    pick      = $urandom_range(0, 99);
    if (pick < 70) nxt = frontier + $urandom_range(0, int'(2 * blk + 4));
    else if (pick < 78) nxt = frontier + $urandom_range(int'(2 * blk + 3), 1300);
    else if (pick < 86) nxt = $urandom_range(0, int'(frontier));
    else if (pick < 89) nxt = 0;
    else if (pick < 95) nxt = longint'($urandom) & POS_MAX;
    else nxt = POS_MAX - $urandom_range(0, 40);
    if (nxt > POS_MAX) nxt = POS_MAX;
    rq.committed = nxt[kvr_pkg::POS_W-1:0];
    if (nxt != 0) frontier = nxt;
    return rq;
  endfunction

  // --------------------------------------------------------------------------
  // Result side: random stalls, check each accepted result
  // --------------------------------------------------------------------------
  initial begin : result_sink
    int stall;
    wait (rst_n === 1'b1);
    forever begin
      stall = draw_gap();
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
      sb.check_result({out_status, out_rewound, out_bulk, out_append_start,
                       out_append_count, out_pad_count, out_visible_full,
                       out_visible_swa});
    end
  end

  // --------------------------------------------------------------------------
  // Watchdog: end the run if no transaction moves for too long
  // --------------------------------------------------------------------------
  initial begin : hang_watch
    int idle_run;
    idle_run = 0;
    while (idle_run < STALL_LIMIT) begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready)) idle_run = 0;
      else idle_run++;
    end
    $display("== FAIL ==");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin : main_seq
    logic [kvr_pkg::CFG_DATA_W-1:0] cap_d, blk_d, swa_d;
    sb = new();
    sb.power_on();
    frontier = 0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // Small ring so wraparound shows: 16 slots, 4 rows, noise columns 16..19,
    // trash column 20, sliding window of 3.
    program_regs(16, 4, 3, 1'b1, 1'b1);

    // queries before any advance: slots empty, noise visible
    poke(kvr_pkg::KIND_QUERY, 0, 0, 0);
    poke(kvr_pkg::KIND_QUERY, 0, 16, 0);
    poke(kvr_pkg::KIND_QUERY, 0, 19, 2);     // noise index above the row: not causal
    poke(kvr_pkg::KIND_QUERY, 0, 20, 0);     // trash column
    poke(kvr_pkg::KIND_QUERY, 0, 2047, 3);   // far beyond the mask row
    poke(kvr_pkg::KIND_QUERY, 0, 5, 15);     // row past block_len
    poke(kvr_pkg::KIND_ADVANCE, 0, 0, 0);    // refused advance
    poke(kvr_pkg::KIND_ADVANCE, 5, 0, 0);    // short append, padded
    poke(kvr_pkg::KIND_QUERY, 0, 4, 1);
    poke(kvr_pkg::KIND_ADVANCE, 15, 0, 0);   // exactly the append width, no pad
    poke(kvr_pkg::KIND_ADVANCE, 40, 0, 0);   // too many new positions: bulk path
    poke(kvr_pkg::KIND_QUERY, 0, 7, 0);      // inside the sliding window
    poke(kvr_pkg::KIND_QUERY, 0, 3, 3);      // in the full window only
    poke(kvr_pkg::KIND_ADVANCE, 40, 0, 0);   // nothing new, all rows padded
    poke(kvr_pkg::KIND_ADVANCE, 12, 0, 0);   // rewind
    poke(kvr_pkg::KIND_QUERY, 0, 13, 0);     // slot emptied by the rewind
    poke(kvr_pkg::KIND_ADVANCE, POS_MAX, 0, 0);
    poke(kvr_pkg::KIND_QUERY, 0, 15, 0);
    poke(kvr_pkg::KIND_ADVANCE, POS_MAX, 0, 0);
    poke(kvr_pkg::KIND_ADVANCE, 1, 0, 0);    // rewind from the top of the range
    poke(kvr_pkg::KIND_QUERY, POS_MAX, 0, 0); // committed field ignored on a query

    // Random phases, each under its own register setting; the sender waits
    // for every result before the registers change.
    for (int phase = 0; phase < 8; phase++) begin
      settle_idle();
      case (phase)
        0: program_regs(1024, 16, 0, 1'b1, 1'b1);
        1: program_regs(1, 1, kvr_pkg::CFG_DATA_W'(POS_MAX), 1'b1, 1'b1);
        2: program_regs(0, 0, 1, 1'b0, 1'b1);
        3: program_regs(2047, 31, 7, 1'b1, 1'b0);
        4: program_regs(37, 7, kvr_pkg::CFG_DATA_W'($urandom_range(1, 60)), 1'b1, 1'b1);
        5: program_regs(200, 9, 20, 1'b0, 1'b0);
        default: begin
          // upper data bits beyond the register width are junk
          cap_d = ($urandom_range(0, 3) == 0)
                ? kvr_pkg::CFG_DATA_W'($urandom_range(0, 2047))
                : kvr_pkg::CFG_DATA_W'($urandom_range(1, 120));
          cap_d = cap_d | (kvr_pkg::CFG_DATA_W'($urandom) & 31'h7FFF_F800);
          blk_d = kvr_pkg::CFG_DATA_W'($urandom_range(0, 31))
                | (kvr_pkg::CFG_DATA_W'($urandom) & 31'h7FFF_FFE0);
          swa_d = $urandom_range(0, 1) ? kvr_pkg::CFG_DATA_W'($urandom_range(0, 80))
                                       : kvr_pkg::CFG_DATA_W'($urandom);
          program_regs(cap_d, blk_d, swa_d, 1'($urandom), 1'($urandom));
        end
      endcase
      for (int n = 0; n < 141; n++) begin
        // flip between idling and back-to-back stretches now and then
        if ($urandom_range(0, 59) == 0) calm = !calm;
        send_request(make_request());
      end
    end

    settle_idle();
    if (sb.mismatches == 0 && sb.expected_results.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
